### sv/fbm_pkg.sv
// Shared types and constants for the frame buffer mirror pixel writer.
// No dependencies; imported by every module of the block.
package fbm_pkg;

	localparam int DIM_W   = 13;
	localparam int SCALE_W = 19;
	localparam int COORD_W = 15;
	localparam int ADDR_W  = 26;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int MULA_W  = 15;
	localparam int MULB_W  = 19;
	localparam int PROD_W  = MULA_W + MULB_W;

	localparam logic [SCALE_W-1:0] ONE_Q16    = 19'h10000;
	localparam logic [7:0]         ALPHA_BYTE = 8'hFF;
	localparam logic [2:0]         BPP_FOUR   = 3'd4;
	localparam logic [2:0]         BPP_THREE  = 3'd3;

	localparam int FMT_FOUR    = 0;
	localparam int FMT_BGR     = 1;
	localparam int FMT_STRETCH = 2;

	typedef enum logic [2:0] {
		REG_ENABLE,
		REG_FORMAT,
		REG_RAW_W,
		REG_RAW_H,
		REG_TEX_W,
		REG_TEX_H,
		REG_SCALE_X,
		REG_SCALE_Y
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MULX,
		ST_MULY,
		ST_MULB,
		ST_BASE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic               enable;
		logic [2:0]         fmt;
		logic [DIM_W-1:0]   raw_w;
		logic [DIM_W-1:0]   raw_h;
		logic [DIM_W-1:0]   tex_w;
		logic [DIM_W-1:0]   tex_h;
		logic [SCALE_W-1:0] scale_x;
		logic [SCALE_W-1:0] scale_y;
	} cfg_t;

endpackage

### sv/fbm_regs.sv
// APB register file holding the mirror configuration.
// Depends on fbm_pkg for the register map and the cfg_t bundle.
module fbm_regs import fbm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable  <= 1'b0;
			cfg_q.fmt     <= 3'd0;
			cfg_q.raw_w   <= '0;
			cfg_q.raw_h   <= '0;
			cfg_q.tex_w   <= DIM_W'(1);
			cfg_q.tex_h   <= DIM_W'(1);
			cfg_q.scale_x <= ONE_Q16;
			cfg_q.scale_y <= ONE_Q16;
		end else if (wr_en) begin
			case (idx)
				REG_ENABLE:  cfg_q.enable  <= pwdata[0];
				REG_FORMAT:  cfg_q.fmt     <= pwdata[2:0];
				REG_RAW_W:   cfg_q.raw_w   <= pwdata[DIM_W-1:0];
				REG_RAW_H:   cfg_q.raw_h   <= pwdata[DIM_W-1:0];
				REG_TEX_W:   cfg_q.tex_w   <= pwdata[DIM_W-1:0];
				REG_TEX_H:   cfg_q.tex_h   <= pwdata[DIM_W-1:0];
				REG_SCALE_X: cfg_q.scale_x <= pwdata[SCALE_W-1:0];
				REG_SCALE_Y: cfg_q.scale_y <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_ENABLE:  prdata = PDATA_W'(cfg_q.enable);
			REG_FORMAT:  prdata = PDATA_W'(cfg_q.fmt);
			REG_RAW_W:   prdata = PDATA_W'(cfg_q.raw_w);
			REG_RAW_H:   prdata = PDATA_W'(cfg_q.raw_h);
			REG_TEX_W:   prdata = PDATA_W'(cfg_q.tex_w);
			REG_TEX_H:   prdata = PDATA_W'(cfg_q.tex_h);
			REG_SCALE_X: prdata = PDATA_W'(cfg_q.scale_x);
			REG_SCALE_Y: prdata = PDATA_W'(cfg_q.scale_y);
			default:     prdata = '0;
		endcase
	end

endmodule

### sv/fbm_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on fbm_pkg for operand widths.
module fbm_mul import fbm_pkg::*; (
	input  logic              clk,
	input  logic [MULA_W-1:0] a,
	input  logic [MULB_W-1:0] b,
	output logic [PROD_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

### sv/framebuffer_mirror_pixel_writer_core.sv
// Frame buffer mirror pixel writer: sequencer around one shared multiplier.
// A pixel in range steps through column scale, row scale, row base multiply and first address, then
// one write per cycle, up to MAX_BLOCK^2 for a stretched block; the next pixel is taken in the cycle
// after the last write. Clipped pixels return to idle after the row base multiply and give no
// writes; rejected pixels are taken while idle with no writes.
// arst_n clears the sequencer and loads register reset values. Depends on fbm_pkg, fbm_regs, fbm_mul.
module framebuffer_mirror_pixel_writer_core import fbm_pkg::*; #(
	parameter int MAX_DIM   = 4096,
	parameter int MAX_BLOCK = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [12:0]        pos_x,
	input  logic [12:0]        pos_y,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic               strobe,
	output logic [ADDR_W-1:0]  byte_address,
	output logic [31:0]        pixel_word,
	output logic               four_bytes,
	output logic               last
);

	localparam int CNT_W = (MAX_BLOCK < 2) ? 1 : $clog2(MAX_BLOCK + 1);
	localparam logic [14:0] DIM_LIM = 15'(MAX_DIM);
	localparam logic [3:0]  BLK_LIM = 4'(MAX_BLOCK);

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if ({2'b0, v} > DIM_LIM) r = DIM_LIM[DIM_W-1:0];
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] blk_len(input logic [SCALE_W-1:0] ratio);
		logic [3:0] n;
		n = {1'b0, ratio[18:16]} + 4'd1 + {3'b0, |ratio[15:0]};
		if (n > BLK_LIM) n = BLK_LIM;
		return n[CNT_W-1:0];
	endfunction

	cfg_t cfg;

	fbm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic [MULA_W-1:0] mul_a;
	logic [MULB_W-1:0] mul_b;
	logic [PROD_W-1:0] prod_q;

	fbm_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	state_t state_q, state_d;

	logic [DIM_W-1:0]   rw_c, rh_c, tw_c, th_c;
	logic               four_c, stretch_c;
	logic [COORD_W-1:0] stride_c;
	logic               accept, reject;
	logic [31:0]        word_c;

	logic [11:0]        px_q, py_q;
	logic [SCALE_W-1:0] sx_q, sy_q;
	logic [CNT_W-1:0]   nx_q, ny_q, xi_q, yi_q;
	logic [COORD_W-1:0] x_q, y_q, col_q, row_q, y_c;
	logic [ADDR_W-1:0]  row_base_q, addr_q, xbpp_q;
	logic [16:0]        xbpp_c;
	logic [31:0]        word_q;
	logic               four_q;
	logic               next_col, next_row, clipped;

	assign rw_c      = clamp_dim(cfg.raw_w);
	assign rh_c      = clamp_dim(cfg.raw_h);
	assign tw_c      = clamp_dim(cfg.tex_w);
	assign th_c      = clamp_dim(cfg.tex_h);
	assign four_c    = cfg.fmt[FMT_FOUR];
	assign stretch_c = cfg.fmt[FMT_STRETCH];
	assign stride_c  = four_c ? {rw_c, 2'b0} : ({1'b0, rw_c, 1'b0} + {2'b0, rw_c});

	assign accept = start && !busy;
	assign reject = pos_x[12] || pos_y[12] || (pos_x >= tw_c) || (pos_y >= th_c)
		|| !cfg.enable;

	assign word_c[7:0]   = cfg.fmt[FMT_BGR] ? blue : red;
	assign word_c[15:8]  = green;
	assign word_c[23:16] = cfg.fmt[FMT_BGR] ? red : blue;
	assign word_c[31:24] = four_c ? ALPHA_BYTE : 8'd0;

	assign y_c     = prod_q[30:16];
	assign xbpp_c  = four_q ? {x_q, 2'b0} : ({1'b0, x_q, 1'b0} + {2'b0, x_q});
	assign clipped = (x_q >= {2'b0, rw_c}) || (y_c >= {2'b0, rh_c});

	assign next_col = (({1'b0, xi_q} + 1'b1) < {1'b0, nx_q})
		&& (({1'b0, col_q} + 16'd1) < {3'b0, rw_c});
	assign next_row = (({1'b0, yi_q} + 1'b1) < {1'b0, ny_q})
		&& (({1'b0, row_q} + 16'd1) < {3'b0, rh_c});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		case (state_q)
			ST_IDLE: begin
				if (start && !reject) state_d = ST_MULX;
			end
			ST_MULX: begin
				mul_a   = {3'b0, px_q};
				mul_b   = sx_q;
				state_d = ST_MULY;
			end
			ST_MULY: begin
				mul_a   = {3'b0, py_q};
				mul_b   = sy_q;
				state_d = ST_MULB;
			end
			ST_MULB: begin
				mul_a   = stride_c;
				mul_b   = {4'b0, y_c};
				state_d = clipped ? ST_IDLE : ST_BASE;
			end
			ST_BASE: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!next_col && !next_row) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					px_q   <= pos_x[11:0];
					py_q   <= pos_y[11:0];
					sx_q   <= stretch_c ? cfg.scale_x : ONE_Q16;
					sy_q   <= stretch_c ? cfg.scale_y : ONE_Q16;
					nx_q   <= stretch_c ? blk_len(cfg.scale_x) : CNT_W'(1);
					ny_q   <= stretch_c ? blk_len(cfg.scale_y) : CNT_W'(1);
					word_q <= word_c;
					four_q <= four_c;
				end
			end
			ST_MULY: x_q <= prod_q[30:16];
			ST_MULB: y_q <= y_c;
			ST_BASE: begin
				row_base_q <= prod_q[ADDR_W-1:0];
				xbpp_q     <= ADDR_W'(xbpp_c);
				addr_q     <= prod_q[ADDR_W-1:0] + ADDR_W'(xbpp_c);
				col_q      <= x_q;
				row_q      <= y_q;
				xi_q       <= '0;
				yi_q       <= '0;
			end
			ST_EMIT: begin
				if (next_col) begin
					addr_q <= addr_q + ADDR_W'(four_q ? BPP_FOUR : BPP_THREE);
					col_q  <= col_q + 1'b1;
					xi_q   <= xi_q + 1'b1;
				end else if (next_row) begin
					row_base_q <= row_base_q + ADDR_W'(stride_c);
					addr_q     <= row_base_q + ADDR_W'(stride_c) + xbpp_q;
					col_q      <= x_q;
					row_q      <= row_q + 1'b1;
					xi_q       <= '0;
					yi_q       <= yi_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign strobe       = (state_q == ST_EMIT);
	assign byte_address = addr_q;
	assign pixel_word   = word_q;
	assign four_bytes   = four_q;
	assign last         = strobe && !next_col && !next_row;

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("write strobe outside busy");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		last |=> !busy)
		else $error("block still busy after last write");

	a_run_on: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> strobe)
		else $error("write run broke before last");

	a_first_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(strobe) |-> ($past(state_q) == ST_BASE))
		else $error("write run started without address setup");

endmodule

### tb/sv/fbm_tb_pkg.sv
// Scoreboard for the frame buffer mirror pixel writer testbench: predicts the byte writes
// that mirror each accepted pixel and checks them in order against the block's output.
// Depends on fbm_pkg.
package fbm_tb_pkg;
	import fbm_pkg::*;

	localparam longint unsigned MIRROR_MAX_DIM   = 4096;
	localparam longint unsigned MIRROR_MAX_BLOCK = 8;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [31:0]       word;
		logic              four;
		logic              last;
	} fb_write_t;

	class mirror_scoreboard;
		int unsigned        mismatches;
		fb_write_t          pending_writes[$];
		logic               enable;
		logic [2:0]         fmt;
		logic [DIM_W-1:0]   raw_w;
		logic [DIM_W-1:0]   raw_h;
		logic [DIM_W-1:0]   tex_w;
		logic [DIM_W-1:0]   tex_h;
		logic [SCALE_W-1:0] scale_x;
		logic [SCALE_W-1:0] scale_y;

		function new();
			mismatches = 0;
			enable     = 1'b0;
			fmt        = 3'd0;
			raw_w      = '0;
			raw_h      = '0;
			tex_w      = 13'd1;
			tex_h      = 13'd1;
			scale_x    = ONE_Q16;
			scale_y    = ONE_Q16;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] value);
			case (idx)
				REG_ENABLE:  enable  = value[0];
				REG_FORMAT:  fmt     = value[2:0];
				REG_RAW_W:   raw_w   = value[DIM_W-1:0];
				REG_RAW_H:   raw_h   = value[DIM_W-1:0];
				REG_TEX_W:   tex_w   = value[DIM_W-1:0];
				REG_TEX_H:   tex_h   = value[DIM_W-1:0];
				REG_SCALE_X: scale_x = value[SCALE_W-1:0];
				REG_SCALE_Y: scale_y = value[SCALE_W-1:0];
				default: ;
			endcase
		endfunction

		function longint unsigned clamp_dim(logic [DIM_W-1:0] v);
			return (v > MIRROR_MAX_DIM) ? MIRROR_MAX_DIM : longint'(v);
		endfunction

		function longint unsigned block_span(logic [SCALE_W-1:0] ratio);
			longint unsigned n;
			n = longint'(ratio[SCALE_W-1:16]) + 1 + ((ratio[15:0] != 0) ? 1 : 0);
			return (n > MIRROR_MAX_BLOCK) ? MIRROR_MAX_BLOCK : n;
		endfunction

		function int unsigned outstanding();
			return pending_writes.size();
		endfunction

		// Expected writes for one accepted pixel word.
		function void note_pixel(logic [12:0] px, logic [12:0] py,
				logic [7:0] r, logic [7:0] g, logic [7:0] b);
			logic signed [12:0] sx;
			logic signed [12:0] sy;
			longint unsigned    x, y, rw, rh, tw, th, nx, ny, bpp, yi, xi;
			logic [31:0]        word;
			fb_write_t          w;
			sx = px;
			sy = py;
			if (sx < 0 || sy < 0)
				return;
			x  = longint'(px);
			y  = longint'(py);
			rw = clamp_dim(raw_w);
			rh = clamp_dim(raw_h);
			tw = clamp_dim(tex_w);
			th = clamp_dim(tex_h);
			if (x >= tw || y >= th || !enable)
				return;
			bpp = fmt[FMT_FOUR] ? 4 : 3;
			nx  = 1;
			ny  = 1;
			if (fmt[FMT_STRETCH]) begin
				x  = (x * scale_x) >> 16;
				y  = (y * scale_y) >> 16;
				nx = block_span(scale_x);
				ny = block_span(scale_y);
			end
			word = fmt[FMT_BGR] ? {8'h00, r, g, b} : {8'h00, b, g, r};
			if (fmt[FMT_FOUR])
				word[31:24] = ALPHA_BYTE;
			w.word = word;
			w.four = fmt[FMT_FOUR];
			w.last = 1'b0;
			for (yi = 0; yi < ny && y + yi < rh; yi++) begin
				for (xi = 0; xi < nx && x + xi < rw; xi++) begin
					w.addr = ADDR_W'(rw * bpp * (y + yi) + (x + xi) * bpp);
					pending_writes.push_back(w);
				end
			end
			if (pending_writes.size() != 0 && (y < rh && x < rw))
				pending_writes[pending_writes.size()-1].last = 1'b1;
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			if (mismatches <= 30)
				$display("%0t mismatch: %s", $realtime, msg);
		endtask

		task check_write(logic [ADDR_W-1:0] addr, logic [31:0] word, logic four, logic last);
			fb_write_t e;
			if (pending_writes.size() == 0) begin
				report_mismatch($sformatf("unexpected write addr=%h word=%h", addr, word));
				return;
			end
			e = pending_writes.pop_front();
			if (addr !== e.addr)
				report_mismatch($sformatf("byte_address %h, want %h", addr, e.addr));
			if (word !== e.word)
				report_mismatch($sformatf("pixel_word %h, want %h at %h", word, e.word, e.addr));
			if (four !== e.four)
				report_mismatch($sformatf("four_bytes %b, want %b at %h", four, e.four, e.addr));
			if (last !== e.last)
				report_mismatch($sformatf("last %b, want %b at %h", last, e.last, e.addr));
		endtask
	endclass

endpackage

### tb/sv/tb_top.sv
// Top of the frame buffer mirror pixel writer testbench: clock, reset, register and pixel
// word drivers, output monitor and watchdog. Depends on fbm_pkg, fbm_tb_pkg and the core.
module tb_top;
	import fbm_pkg::*;
	import fbm_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 16;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [12:0]        pos_x;
	logic [12:0]        pos_y;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               strobe;
	logic [ADDR_W-1:0]  byte_address;
	logic [31:0]        pixel_word;
	logic               four_bytes;
	logic               last;

	mirror_scoreboard sb;
	int unsigned      quiet_cycles;
	bit               no_gaps;

	framebuffer_mirror_pixel_writer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.red(red),
		.green(green),
		.blue(blue),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.strobe(strobe),
		.byte_address(byte_address),
		.pixel_word(pixel_word),
		.four_bytes(four_bytes),
		.last(last)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if (start && !busy)
				sb.note_pixel(pos_x, pos_y, red, green, blue);
			if (strobe)
				sb.check_write(byte_address, pixel_word, four_bytes, last);
			if ((start && !busy) || strobe || (psel && penable && pwrite && pready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("** framebuffer_mirror_pixel_writer_core: FAILED **");
		$finish;
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic program_mirror(logic en, logic [2:0] fmt, logic [12:0] rw, logic [12:0] rh,
			logic [12:0] tw, logic [12:0] th, logic [18:0] sx, logic [18:0] sy);
		write_reg(REG_ENABLE, 32'(en));
		write_reg(REG_FORMAT, 32'(fmt));
		write_reg(REG_RAW_W, 32'(rw));
		write_reg(REG_RAW_H, 32'(rh));
		write_reg(REG_TEX_W, 32'(tw));
		write_reg(REG_TEX_H, 32'(th));
		write_reg(REG_SCALE_X, 32'(sx));
		write_reg(REG_SCALE_Y, 32'(sy));
	endtask

	task automatic send_pixel(logic [12:0] x, logic [12:0] y,
			logic [7:0] r, logic [7:0] g, logic [7:0] b);
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < 15) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		pos_x <= x;
		pos_y <= y;
		red   <= r;
		green <= g;
		blue  <= b;
		do @(posedge clk); while (busy);
	endtask

	// Hold off until every predicted write has come out and the core is idle.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.outstanding() != 0 || busy)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [12:0] pick_dim(int unsigned lo, int unsigned typ);
		case ($urandom_range(11))
			0: return 13'(lo);
			1: return 13'd4096;
			2: return 13'h1FFF;
			3: return 13'($urandom_range(8191));
			default: return 13'($urandom_range(typ, (lo > 0) ? lo : 1));
		endcase
	endfunction

	function automatic logic [18:0] pick_scale();
		case ($urandom_range(9))
			0: return 19'd0;
			1: return 19'($urandom_range(524287));
			2: return 19'($urandom_range(524287, 491520));
			3: return ONE_Q16;
			default: return 19'($urandom_range(4 * 65536));
		endcase
	endfunction

	task automatic random_config();
		program_mirror($urandom_range(7) != 0, 3'($urandom_range(7)),
			pick_dim(0, 400), pick_dim(0, 400), pick_dim(1, 48), pick_dim(1, 48),
			pick_scale(), pick_scale());
	endtask

	task automatic random_pixel();
		int unsigned tw;
		int unsigned th;
		logic [12:0] x;
		logic [12:0] y;
		tw = (sb.tex_w == 0) ? 1 : ((sb.tex_w > 4096) ? 4096 : sb.tex_w);
		th = (sb.tex_h == 0) ? 1 : ((sb.tex_h > 4096) ? 4096 : sb.tex_h);
		case ($urandom_range(9))
			0: begin
				x = 13'($urandom);
				y = 13'($urandom);
			end
			1: begin
				x = 13'(tw - 1 + $urandom_range(1));
				y = 13'(th - 1 + $urandom_range(1));
			end
			default: begin
				x = 13'($urandom_range(tw - 1));
				y = 13'($urandom_range(th - 1));
			end
		endcase
		send_pixel(x, y, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	initial begin
		int phase;
		int i;
		sb           = new();
		no_gaps      = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		pos_x        = '0;
		pos_y        = '0;
		red          = '0;
		green        = '0;
		blue         = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// mirror off after reset: no writes
		send_pixel(13'd0, 13'd0, 8'h11, 8'h22, 8'h33);
		drain();

		program_mirror(1'b1, 3'b000, 13'd640, 13'd480, 13'd640, 13'd480, ONE_Q16, ONE_Q16);
		send_pixel(13'd0, 13'd0, 8'h00, 8'h00, 8'h00);
		send_pixel(13'd639, 13'd479, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(13'd640, 13'd0, 8'h01, 8'h02, 8'h03);
		send_pixel(13'd0, 13'd480, 8'h04, 8'h05, 8'h06);
		send_pixel(13'h1FFF, 13'd5, 8'h07, 8'h08, 8'h09);
		send_pixel(13'h1000, 13'h1000, 8'hAA, 8'h55, 8'hAA);
		send_pixel(13'h0FFF, 13'd0, 8'h55, 8'hAA, 8'h55);
		send_pixel(13'd17, 13'd33, 8'h12, 8'h34, 8'h56);
		drain();

		// oversized dimensions, four bytes, blue first
		program_mirror(1'b1, 3'b011, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, ONE_Q16, ONE_Q16);
		send_pixel(13'h0FFF, 13'h0FFF, 8'h12, 8'h34, 8'h56);
		send_pixel(13'd100, 13'd200, 8'hFE, 8'h01, 8'h80);
		drain();

		// stretch with clipping at the raw edge
		program_mirror(1'b1, 3'b101, 13'd20, 13'd12, 13'd16, 13'd16, 19'h18000, ONE_Q16);
		send_pixel(13'd0, 13'd0, 8'h10, 8'h20, 8'h30);
		send_pixel(13'd15, 13'd15, 8'h40, 8'h50, 8'h60);
		send_pixel(13'd5, 13'd3, 8'h70, 8'h80, 8'h90);
		send_pixel(13'd12, 13'd10, 8'hA0, 8'hB0, 8'hC0);
		drain();

		// saturated block and scaled pixels clipped off the raw edge
		program_mirror(1'b1, 3'b110, 13'h1FFF, 13'h1FFF, 13'd4096, 13'd4096,
			19'h7FFFF, 19'h78000);
		send_pixel(13'h0FFF, 13'h0FFF, 8'hC3, 8'h3C, 8'h5A);
		send_pixel(13'd1000, 13'd3000, 8'h01, 8'h80, 8'hFF);
		send_pixel(13'd0, 13'd0, 8'h0F, 8'hF0, 8'h00);
		drain();

		// zero scale and scale just under one
		program_mirror(1'b1, 3'b101, 13'd4096, 13'd4096, 13'd8, 13'd8, 19'h00000, 19'h0FFFF);
		send_pixel(13'd7, 13'd7, 8'h66, 8'h77, 8'h88);
		send_pixel(13'd3, 13'd2, 8'h99, 8'hAA, 8'hBB);
		drain();

		program_mirror(1'b0, 3'b001, 13'd64, 13'd64, 13'd64, 13'd64, ONE_Q16, ONE_Q16);
		send_pixel(13'd1, 13'd1, 8'hDE, 8'hAD, 8'hBE);
		drain();

		for (phase = 0; phase < 6; phase++) begin
			random_config();
			for (i = 0; i < 48; i++) begin
				if (phase == 2 && i == 0)
					no_gaps = 1'b1;
				if (phase == 3 && i == 0)
					no_gaps = 1'b0;
				if (phase == 1 && i == 24)
					drain();
				random_pixel();
			end
			drain();
		end

		if (sb.mismatches == 0)
			$display("** framebuffer_mirror_pixel_writer_core: PASSED **");
		else
			$display("** framebuffer_mirror_pixel_writer_core: FAILED **");
		$finish;
	end

endmodule

### framebuffer_mirror_pixel_writer_core.f
sv/fbm_pkg.sv
sv/fbm_regs.sv
sv/fbm_mul.sv
sv/framebuffer_mirror_pixel_writer_core.sv
tb/sv/fbm_tb_pkg.sv
tb/sv/tb_top.sv
